[rtl/hkfd_pkg.sv]
`default_nettype none
package hkfd_pkg;

  localparam logic [7:0] StartMark = 8'h01;
  localparam logic [4:0] TypeMask  = 5'h1f;
  localparam logic [4:0] TypeSps   = 5'd7;
  localparam logic [4:0] TypePps   = 5'd8;
  localparam logic [2:0] ZeroLimit = 3'd4;

  typedef enum logic [3:0] {
    PhHdr1Zeros = 4'd0,
    PhHdr1Type  = 4'd1,
    PhSkip1     = 4'd2,
    PhHdr2Zeros = 4'd3,
    PhHdr2Type  = 4'd4,
    PhSkip2     = 4'd5,
    PhHdr3Zeros = 4'd6,
    PhHdr3Type  = 4'd7,
    PhDone      = 4'd8
  } phase_e;

  // verdict of one frame, handed from the parser to the output stage
  typedef struct packed {
    logic valid;
    logic key;
  } hkfd_res_t;

endpackage
`default_nettype wire

[rtl/hkfd_parser.sv]
`default_nettype none
module hkfd_parser import hkfd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] byte_value_i,
  input  wire logic       last_byte_i,
  output hkfd_res_t       res_o
);

  phase_e     phase_q, phase_d;
  logic [2:0] zr_q, zr_d;
  logic       prev_nz_q, prev_nz_d;
  logic       key_q, key_d;

  logic       byte_zero;
  logic [2:0] zr_inc;
  logic       hdr_marker_ok;
  logic [4:0] nal_type;

  assign byte_zero     = (byte_value_i == 8'h00);
  assign zr_inc        = zr_q + 3'd1;
  assign hdr_marker_ok = (byte_value_i == StartMark) && (zr_q >= 3'd2);
  assign nal_type      = byte_value_i[4:0] & TypeMask;

  always_comb begin
    phase_d   = phase_q;
    zr_d      = zr_q;
    key_d     = key_q;
    prev_nz_d = !byte_zero;
    unique case (phase_q)
      PhHdr1Zeros, PhHdr2Zeros, PhHdr3Zeros: begin
        if (byte_zero) begin
          if (zr_inc >= ZeroLimit) begin
            phase_d = PhDone;
          end else begin
            zr_d = zr_inc;
          end
        end else if (hdr_marker_ok) begin
          // type phase directly follows its zeros phase
          phase_d = phase_e'(phase_q + 4'd1);
        end else begin
          phase_d = PhDone;
        end
      end
      PhHdr1Type: begin
        if (nal_type == TypeSps) begin
          phase_d = PhSkip1;
          zr_d    = 3'd0;
        end else begin
          phase_d = PhDone;
        end
      end
      PhSkip1: begin
        if (byte_zero) begin
          if (zr_inc >= 3'd3) begin
            phase_d = PhHdr2Zeros;
            zr_d    = 3'd2;
          end else begin
            zr_d = zr_inc;
          end
        end else begin
          zr_d = 3'd0;
        end
      end
      PhHdr2Type: begin
        if (nal_type == TypePps) begin
          phase_d = PhSkip2;
          zr_d    = 3'd0;
        end else begin
          phase_d = PhDone;
        end
      end
      PhSkip2: begin
        if (byte_zero && !prev_nz_q) begin
          phase_d = PhHdr3Zeros;
          zr_d    = 3'd1;
        end
      end
      PhHdr3Type: begin
        key_d   = 1'b1;
        phase_d = PhDone;
      end
      PhDone: begin
        phase_d = PhDone;
      end
      default: begin
        phase_d = PhDone;
      end
    endcase
  end

  assign res_o.valid = accept_i && last_byte_i;
  assign res_o.key   = key_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHdr1Zeros;
      zr_q      <= 3'd0;
      prev_nz_q <= 1'b1;
      key_q     <= 1'b0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        phase_q   <= PhHdr1Zeros;
        zr_q      <= 3'd0;
        prev_nz_q <= 1'b1;
        key_q     <= 1'b0;
      end else begin
        phase_q   <= phase_d;
        zr_q      <= zr_d;
        prev_nz_q <= prev_nz_d;
        key_q     <= key_d;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/hkfd_out_stage.sv]
`default_nettype none
module hkfd_out_stage import hkfd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire hkfd_res_t res_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic       key_frame_o
);

  logic out_valid_q, out_key_q;
  logic skid_valid_q, skid_key_q;

  // skid entry catches a verdict while the output register is stalled
  assign room_o      = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign key_frame_o = out_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_i.valid;
      end
    end else if (res_i.valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_key_q <= skid_valid_q ? skid_key_q : res_i.key;
    end else if (res_i.valid) begin
      skid_key_q <= res_i.key;
    end
  end

endmodule
`default_nettype wire

[rtl/h264_key_frame_detector_unit.sv]
// The verdict of the last byte taken is registered in the output stage (or its skid entry) and shows on key_frame_o.
// Throughput: one byte per cycle while the skid entry is empty; the parser state updates on each accepted byte.
// A two-entry output register with skid keeps bytes flowing while a verdict waits.
// Reset: parser returns to the first header with no zeros counted; no request pending.
`default_nettype none
module h264_key_frame_detector_unit import hkfd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] byte_value_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            key_frame_o
);

  hkfd_res_t res;
  logic      room;
  logic      accept;

  assign in_ready_o = room;
  assign accept     = in_valid_i && room;

  hkfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .byte_value_i (byte_value_i),
    .last_byte_i  (last_byte_i),
    .res_o        (res)
  );

  hkfd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .key_frame_o (key_frame_o)
  );

endmodule
`default_nettype wire

[tb/sv/tb_h264_key_frame_detector_unit.sv]
`timescale 1ns / 100ps
module tb_h264_key_frame_detector_unit import hkfd_pkg::*; ();

  typedef enum logic [1:0] {
    VerdOpen   = 2'd0,
    VerdKey    = 2'd1,
    VerdNotKey = 2'd2
  } verdict_e;

  // Tracks the Annex B parse of the current frame and queues one verdict per frame.
  class verdict_board;
    phase_e     phase;
    logic [2:0] zero_cnt;
    logic       prev_nz;
    logic [7:0] type_byte;
    verdict_e   verd;
    logic       exp_key_q[$];
    int         errors;
    int         n_key;
    int         n_plain;

    function new();
      restart_frame();
      type_byte = 8'h00;
      errors    = 0;
      n_key     = 0;
      n_plain   = 0;
    endfunction

    function void restart_frame();
      phase    = PhHdr1Zeros;
      zero_cnt = 3'd0;
      prev_nz  = 1'b1;
      verd     = VerdOpen;
    endfunction

    function void conclude(verdict_e v);
      verd  = v;
      phase = PhDone;
    endfunction

    function void take_zero_run(logic [7:0] b, phase_e type_phase);
      if (b == 8'h00) begin
        if (int'(zero_cnt) + 1 >= int'(ZeroLimit)) conclude(VerdNotKey);
        else zero_cnt = zero_cnt + 3'd1;
      end else if (b == StartMark && zero_cnt >= 3'd2) begin
        phase = type_phase;
      end else begin
        conclude(VerdNotKey);
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [4:0] nal;
      nal = b[4:0] & TypeMask;
      case (phase)
        PhHdr1Zeros: take_zero_run(b, PhHdr1Type);
        PhHdr1Type: begin
          type_byte = b;
          if (nal == TypeSps) begin
            phase    = PhSkip1;
            zero_cnt = 3'd0;
          end else begin
            conclude(VerdNotKey);
          end
        end
        PhSkip1: begin
          // first run of three zeros; two of them count toward the next header
          if (b == 8'h00) begin
            zero_cnt = zero_cnt + 3'd1;
            if (zero_cnt >= 3'd3) begin
              phase    = PhHdr2Zeros;
              zero_cnt = 3'd2;
            end
          end else begin
            zero_cnt = 3'd0;
          end
        end
        PhHdr2Zeros: take_zero_run(b, PhHdr2Type);
        PhHdr2Type: begin
          type_byte = b;
          if (nal == TypePps) begin
            phase    = PhSkip2;
            zero_cnt = 3'd0;
          end else begin
            conclude(VerdNotKey);
          end
        end
        PhSkip2: begin
          if (b == 8'h00 && !prev_nz) begin
            phase    = PhHdr3Zeros;
            zero_cnt = 3'd1;
          end
        end
        PhHdr3Zeros: take_zero_run(b, PhHdr3Type);
        PhHdr3Type: begin
          type_byte = b;
          conclude(VerdKey);
        end
        default: phase = PhDone;
      endcase
      prev_nz = (b != 8'h00);
      if (last) begin
        exp_key_q.push_back(verd == VerdKey);
        restart_frame();
      end
    endfunction

    function void check_verdict(logic key);
      logic exp_key;
      if (exp_key_q.size() == 0) begin
        $error("key_frame result with no frame pending: actual %0d", key);
        errors++;
        return;
      end
      exp_key = exp_key_q.pop_front();
      if (key !== exp_key) begin
        $error("key_frame mismatch: expected %0d, actual %0d", exp_key, key);
        errors++;
      end
      if (exp_key) n_key++;
      else n_plain++;
    endfunction

    function int pending();
      return exp_key_q.size();
    endfunction
  endclass

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [7:0] byte_value_i = 8'h00;
  logic       last_byte_i  = 1'b0;
  logic       out_ready_i  = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       key_frame_o;

  verdict_board sb = new();
  logic [7:0]   frame_q[$];
  logic         calm = 1'b0;
  int           n_sent = 0;
  int           n_frames = 0;

  h264_key_frame_detector_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_value_i (byte_value_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .key_frame_o  (key_frame_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(byte_value_i, last_byte_i);
      if (out_valid_o && out_ready_i) sb.check_verdict(key_frame_o);
    end
  end

  // mostly no gap, some short ones, a few long
  function int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function void add_body(int n);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) frame_q.push_back(8'h00);
      else frame_q.push_back(8'($urandom_range(1, 255)));
    end
  endfunction

  function void add_header(int zeros, logic [7:0] nal_byte);
    repeat (zeros) frame_q.push_back(8'h00);
    frame_q.push_back(StartMark);
    frame_q.push_back(nal_byte);
  endfunction

  function void build_key_frame();
    frame_q.delete();
    add_header($urandom_range(2, 3), {3'($urandom_range(0, 7)), TypeSps});
    add_body($urandom_range(0, 6));
    add_header($urandom_range(3, 4), {3'($urandom_range(0, 7)), TypePps});
    add_body($urandom_range(0, 6));
    add_header($urandom_range(3, 4), 8'($urandom()));
    add_body($urandom_range(0, 4));
  endfunction

  function void break_frame();
    int pos;
    pos = $urandom_range(0, frame_q.size() - 1);
    case ($urandom_range(0, 2))
      0: frame_q[pos] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom());
      1: while (frame_q.size() > pos + 1 && frame_q.size() > 1) void'(frame_q.pop_back());
      default: frame_q.insert(pos, 8'h00);
    endcase
  endfunction

  function void build_noise_frame();
    int r;
    frame_q.delete();
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(0, 7);
      if (r < 4) frame_q.push_back(8'h00);
      else if (r == 4) frame_q.push_back(StartMark);
      else frame_q.push_back(8'($urandom()));
    end
  endfunction

  task automatic send_frame();
    int gap;
    for (int i = 0; i < frame_q.size(); i++) begin
      in_valid_i   <= 1'b1;
      byte_value_i <= frame_q[i];
      last_byte_i  <= (i == frame_q.size() - 1);
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      n_sent++;
      gap = pick_gap();
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    n_frames++;
  endtask

  // sender holds off until every queued verdict has been taken
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  initial begin
    int kind;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // minimal key frame, stray upper bits on the type bytes
    frame_q = '{8'h00, 8'h00, 8'h01, 8'he7, 8'h00, 8'h00, 8'h00, 8'h01,
                8'he8, 8'h00, 8'h00, 8'h00, 8'h01, 8'hff};
    send_frame();
    frame_q = '{8'h00};                      // all-zero frame ends early
    send_frame();
    frame_q = '{8'h00, 8'h01};               // too few zeros
    send_frame();
    frame_q = '{8'h00, 8'h00, 8'h00, 8'h00}; // four zeros
    send_frame();
    frame_q = '{8'h00, 8'h00, 8'h02};        // wrong marker
    send_frame();
    drain();

    while (n_sent < 1300) begin
      calm = (n_frames % 20) < 3;
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        build_key_frame();
      end else if (kind < 8) begin
        build_key_frame();
        break_frame();
      end else begin
        build_noise_frame();
      end
      send_frame();
      if (n_frames % 25 == 24) drain();
    end
    calm = 1'b0;
    drain();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d bytes in %0d frames; checked %0d key and %0d non-key verdicts.",
             n_sent, n_frames, sb.n_key, sb.n_plain);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[h264_key_frame_detector_unit.f]
rtl/hkfd_pkg.sv
rtl/hkfd_parser.sv
rtl/hkfd_out_stage.sv
rtl/h264_key_frame_detector_unit.sv
tb/sv/tb_h264_key_frame_detector_unit.sv
